### sv/dles_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dles_pkg
// Shared types for the double ended list store: commands, status codes and
// the control word that drives the row of storage cells.
// ----------------------------------------------------------------------------
package dles_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_TAIL  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_DUMP       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CHAIN_HOLD       = 3'd0,
      CHAIN_PUSH_FRONT = 3'd1,
      CHAIN_PUSH_TAIL  = 3'd2,
      CHAIN_POP        = 3'd3,
      CHAIN_ROTATE     = 3'd4
   } chain_op_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_DUMP = 1'b1
   } state_type;

   typedef struct packed {
      chain_op_type op;
      logic         active;
   } chain_ctl_type;

   localparam int ITEM_COUNT_W = 7;
   localparam int VALUE_W      = 32;

endpackage

### sv/dles_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dles_cell
// One storage slot of the list; loads from its neighbors, the new value or
// the front slot according to the chain control word.
// ----------------------------------------------------------------------------
module dles_cell
   import dles_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
) (
   input  logic                  clock,
   input  chain_ctl_type         ctl,
   input  logic [CNT_W-1:0]      cnt,
   input  logic [DATA_WIDTH-1:0] data_left,
   input  logic [DATA_WIDTH-1:0] data_right,
   input  logic [DATA_WIDTH-1:0] data_head,
   input  logic [DATA_WIDTH-1:0] data_new,
   output logic [DATA_WIDTH-1:0] data_q
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.active) begin
         case (ctl.op)
            CHAIN_PUSH_FRONT: data_in = data_left;
            CHAIN_PUSH_TAIL: begin
               if (cnt == CNT_W'(INDEX)) data_in = data_new;
            end
            CHAIN_POP: data_in = data_right;
            CHAIN_ROTATE: begin
               if (CNT_W'(INDEX + 1) == cnt) begin
                  data_in = data_head;
               end else if (CNT_W'(INDEX + 1) < cnt) begin
                  data_in = data_right;
               end
            end
            default: data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

### sv/dles_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dles_ctrl
// Command sequencer: keeps the entry count, steers the cell row, walks the
// row during a dump and holds the result register.
// ----------------------------------------------------------------------------
module dles_ctrl
   import dles_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int CNT_W = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  cmd_type                 req_cmd,
   input  logic [VALUE_W-1:0]      head_value,
   output chain_ctl_type           ctl,
   output logic [CNT_W-1:0]        cnt,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [VALUE_W-1:0]      rsp_value,
   output status_type              rsp_status,
   output logic [ITEM_COUNT_W-1:0] rsp_count,
   output logic                    rsp_last
);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic                      valid_ff, valid_in;
   logic [VALUE_W-1:0]        value_ff, value_in;
   status_type                status_ff, status_in;
   logic [ITEM_COUNT_W-1:0]   ocount_ff, ocount_in;
   logic                      last_ff, last_in;
   logic                      out_free;
   logic                      fire;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && out_free;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      valid_in   = valid_ff && !rsp_tready;
      value_in   = value_ff;
      status_in  = status_ff;
      ocount_in  = ocount_ff;
      last_in    = last_ff;
      ctl.op     = CHAIN_HOLD;
      ctl.active = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            if (fire) begin
               valid_in  = 1'b1;
               value_in  = '0;
               last_in   = 1'b1;
               status_in = ST_OK;
               case (req_cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_TAIL: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                        ocount_in = ITEM_COUNT_W'(count_ff);
                     end else begin
                        ctl.active = 1'b1;
                        ctl.op     = (req_cmd == CMD_PUSH_FRONT) ? CHAIN_PUSH_FRONT
                                                                 : CHAIN_PUSH_TAIL;
                        count_in   = count_ff + 1'b1;
                        ocount_in  = ITEM_COUNT_W'(count_ff + 1'b1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        ocount_in = '0;
                     end else begin
                        ctl.active = 1'b1;
                        ctl.op     = CHAIN_POP;
                        count_in   = count_ff - 1'b1;
                        ocount_in  = ITEM_COUNT_W'(count_ff - 1'b1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        ocount_in = '0;
                     end else begin
                        valid_in = 1'b0;
                        rem_in   = count_ff;
                        state_in = STATE_DUMP;
                     end
                  end
                  default: begin
                     status_in = ST_EMPTY;
                  end
               endcase
            end
         end
         STATE_DUMP: begin
            if (out_free) begin
               valid_in   = 1'b1;
               value_in   = head_value;
               status_in  = ST_OK;
               ocount_in  = ITEM_COUNT_W'(count_ff);
               last_in    = (rem_ff == CNT_W'(1));
               rem_in     = rem_ff - 1'b1;
               ctl.active = 1'b1;
               ctl.op     = CHAIN_ROTATE;
               if (rem_ff == CNT_W'(1)) state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         count_ff <= '0;
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      ocount_ff <= ocount_in;
      last_ff   <= last_in;
   end

   assign cnt        = count_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = ocount_ff;
   assign rsp_last   = last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_dump_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_DUMP |-> rem_ff != '0 && rem_ff <= count_ff)
      else $error("dump counter out of range");

   a_dump_blocks_input: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_DUMP |-> !req_tready)
      else $error("input taken during dump");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff == ST_FULL |-> ocount_ff == ITEM_COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_DUMP && out_free && rem_ff == CNT_W'(1)
         |=> state_ff == STATE_IDLE && valid_ff && last_ff)
      else $error("dump did not finish with last transfer");
`endif

endmodule

### sv/double_ended_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_list_store_core
// Double ended list of signed values kept in a row of shifting cells; the
// front of the list is always cell 0.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tuser: command, tdata: value
//   rsp_     out  rsp_tvalid/tready     tuser: status, tdata: value, count
//                                        tlast: final result of a command
//
// push and pop are accepted back to back while rsp_ drains.
// during a dump of n entries the cell row rotates by one slot per cycle while
// rsp_ drains and cell 0 feeds the result register; req_ is held off meanwhile.
// reset is synchronous and clears the count and sequencer; cell data is kept.
// rsp_tready low while rsp_tvalid is high freezes the result register and the cell row.
// ----------------------------------------------------------------------------
module double_ended_list_store_core
   import dles_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] item_value, [38:32] item_count, [39] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   chain_ctl_type           ctl;
   logic [CNT_W-1:0]        cnt;
   logic [DATA_WIDTH-1:0]   cell_q [DEPTH];
   logic [DATA_WIDTH-1:0]   new_data;
   logic [VALUE_W-1:0]      head_value;
   logic [VALUE_W-1:0]      rsp_value;
   status_type              rsp_status;
   logic [ITEM_COUNT_W-1:0] rsp_count;

   assign new_data = DATA_WIDTH'(req_tdata);

   generate
      if (DATA_WIDTH < VALUE_W) begin : g_narrow
         assign head_value = VALUE_W'($signed(cell_q[0]));
      end else begin : g_wide
         assign head_value = cell_q[0][VALUE_W-1:0];
      end
   endgenerate

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = new_data;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_d = cell_q[i];
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end
      dles_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cnt        (cnt),
         .data_left  (left_d),
         .data_right (right_d),
         .data_head  (cell_q[0]),
         .data_new   (new_data),
         .data_q     (cell_q[i])
      );
   end

   dles_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (cmd_type'(req_tuser)),
      .head_value (head_value),
      .ctl        (ctl),
      .cnt        (cnt),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

endmodule

### dv/double_ended_list_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_list_store_core_tb
// Self-checking bench for the double ended list store. A table of directed
// commands covers the empty, extreme and wrap cases. Random push, pop and
// dump traffic follows, including filling to capacity, overflowing and
// draining past empty. Both stream sides idle in several phases, and one
// long receiver hold-off backs the block up. Every result transfer is
// checked field by field against a behavioral list kept in the bench.
// ----------------------------------------------------------------------------
module double_ended_list_store_core_tb;
   import dles_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      logic [6:0]  count;
      logic        last;
   } list_rsp_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] value;
      logic        typed;
      status_type  status;
      logic [6:0]  count;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic [1:0]  req_tuser;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] item_value, [38:32] item_count, [39] zero
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;

   // bench copy of the list
   logic [31:0] list_mem [LIST_DEPTH];
   int          front_idx;
   int          held;

   list_rsp_type pending_rsp [$];

   int fail_count;
   int cycle_count;
   int n_items;
   int n_checked;
   int n_full;
   int n_empty;
   int max_dump;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_len;

   double_ended_list_store_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: long hold-off first, else random stall
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      list_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer: value %h status %0d count %0d",
                   rsp_tdata[31:0], rsp_tuser, rsp_tdata[38:32]);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            n_checked++;
            if (rsp_tdata[31:0] !== exp_rsp.value) begin
               $error("item_value mismatch: expected %h actual %h",
                      exp_rsp.value, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tuser !== exp_rsp.status) begin
               $error("status mismatch: expected %0d actual %0d", exp_rsp.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[38:32] !== exp_rsp.count) begin
               $error("item_count mismatch: expected %0d actual %0d",
                      exp_rsp.count, rsp_tdata[38:32]);
               fail_count++;
            end
            if (rsp_tlast !== exp_rsp.last) begin
               $error("last mismatch: expected %0d actual %0d", exp_rsp.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // applies one command to the bench list and queues its results
   task automatic list_predict(input cmd_type cmd, input logic [31:0] v);
      list_rsp_type r;
      int k;
      r = '{value: 32'd0, status: ST_OK, count: 7'd0, last: 1'b1};
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_TAIL: begin
            if (held >= LIST_DEPTH) begin
               r.status = ST_FULL;
               n_full++;
            end else if (cmd == CMD_PUSH_FRONT) begin
               front_idx = (front_idx + LIST_DEPTH - 1) % LIST_DEPTH;
               list_mem[front_idx] = v;
               held++;
            end else begin
               list_mem[(front_idx + held) % LIST_DEPTH] = v;
               held++;
            end
            r.count = 7'(held);
            pending_rsp.insert(pending_rsp.size(), r);
         end
         CMD_POP_FRONT: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
               n_empty++;
            end else begin
               front_idx = (front_idx + 1) % LIST_DEPTH;
               held--;
            end
            r.count = 7'(held);
            pending_rsp.insert(pending_rsp.size(), r);
         end
         default: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
               n_empty++;
               pending_rsp.insert(pending_rsp.size(), r);
            end else begin
               if (held > max_dump) max_dump = held;
               r.count = 7'(held);
               for (k = 0; k < held; k++) begin
                  r.value = list_mem[(front_idx + k) % LIST_DEPTH];
                  r.last = (k == held - 1);
                  pending_rsp.insert(pending_rsp.size(), r);
               end
            end
         end
      endcase
   endtask

   // one request transfer; a typed row replaces the predicted result
   task automatic send_item(input cmd_type cmd, input logic [31:0] v,
                            input logic typed, input list_rsp_type typed_rsp);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      list_predict(cmd, v);
      if (typed) begin
         void'(pending_rsp.pop_back());
         pending_rsp.insert(pending_rsp.size(), typed_rsp);
      end
      n_items++;
      @(negedge clock);
   endtask

   task automatic send_plain(input cmd_type cmd, input logic [31:0] v);
      send_item(cmd, v, 1'b0, '0);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type pick_push();
      return ($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_TAIL;
   endfunction

   function automatic dir_row_type directed_row(input int idx);
      case (idx)
         0:  return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 7'd0};
         1:  return '{CMD_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY, 7'd0};
         2:  return '{CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, ST_OK,    7'd1};
         3:  return '{CMD_PUSH_TAIL,  32'h8000_0000, 1'b1, ST_OK,    7'd2};
         4:  return '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_OK,    7'd3};
         5:  return '{CMD_PUSH_TAIL,  32'hffff_ffff, 1'b1, ST_OK,    7'd4};
         6:  return '{CMD_DUMP,       32'h0000_0000, 1'b0, ST_OK,    7'd0};
         7:  return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,    7'd3};
         8:  return '{CMD_POP_FRONT,  32'hffff_ffff, 1'b1, ST_OK,    7'd2};
         9:  return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,    7'd1};
         10: return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,    7'd0};
         11: return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 7'd0};
         12: return '{CMD_PUSH_TAIL,  32'haaaa_aaaa, 1'b1, ST_OK,    7'd1};
         13: return '{CMD_PUSH_FRONT, 32'h5555_5555, 1'b1, ST_OK,    7'd2};
         14: return '{CMD_DUMP,       32'h0000_0000, 1'b0, ST_OK,    7'd0};
         15: return '{CMD_PUSH_TAIL,  32'h0000_0001, 1'b1, ST_OK,    7'd3};
         16: return '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,    7'd2};
         17: return '{CMD_DUMP,       32'h0000_0000, 1'b0, ST_OK,    7'd0};
         18: return '{CMD_DUMP,       32'hffff_ffff, 1'b0, ST_OK,    7'd0};
         19: return '{CMD_POP_FRONT,  32'h1234_5678, 1'b1, ST_OK,    7'd1};
         default: return '{CMD_POP_FRONT, 32'h0000_0000, 1'b1, ST_OK, 7'd0};
      endcase
   endfunction

   // mixed traffic, alternating between filling and draining stretches
   task automatic run_random(input int n, input int sidle, input int rstall);
      int i;
      int bias;
      int r;
      sender_idle_pct = sidle;
      receiver_stall_pct = rstall;
      for (i = 0; i < n; i++) begin
         bias = ((i / 16) % 2 == 0) ? 70 : 25;
         r = $urandom_range(0, 99);
         if (r < 8) send_plain(CMD_DUMP, pick_value());
         else if (r - 8 < bias) send_plain(pick_push(), pick_value());
         else send_plain(CMD_POP_FRONT, pick_value());
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      dir_row_type row;
      int i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      front_idx = 0;
      held = 0;
      fail_count = 0;
      cycle_count = 0;
      n_items = 0;
      n_checked = 0;
      n_full = 0;
      n_empty = 0;
      max_dump = 0;
      hold_len = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < 21; i++) begin
         row = directed_row(i);
         send_item(row.cmd, row.value, row.typed,
                   '{value: 32'd0, status: row.status, count: row.count, last: 1'b1});
      end
      wait_drained();

      // fill past capacity, dump full list, drain past empty, no idling
      for (i = 0; i < LIST_DEPTH + 3; i++) send_plain(pick_push(), pick_value());
      send_plain(CMD_DUMP, pick_value());
      for (i = 0; i < LIST_DEPTH + 2; i++) send_plain(CMD_POP_FRONT, pick_value());
      send_plain(CMD_DUMP, pick_value());
      wait_drained();

      run_random(50, 83, 0);
      wait_drained();
      run_random(50, 0, 83);
      wait_drained();
      run_random(50, 38, 38);
      wait_drained();

      // long receiver hold-off while requests keep coming
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      @(posedge clock);
      hold_len = 250;
      @(negedge clock);
      for (i = 0; i < 30; i++) begin
         if (i == 15) send_plain(CMD_DUMP, pick_value());
         else if (i % 4 == 3) send_plain(CMD_POP_FRONT, pick_value());
         else send_plain(pick_push(), pick_value());
      end
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d commands and %0d checked result transfers", n_items, n_checked);
      $display("full rejects %0d, empty results %0d, longest dump %0d entries",
               n_full, n_empty, max_dump);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
sv/dles_pkg.sv
sv/dles_cell.sv
sv/dles_ctrl.sv
sv/double_ended_list_store_core.sv
dv/double_ended_list_store_core_tb.sv
